// ===== src/erd_pkg.sv =====
// Shared types and constants of the DRAM ECC error rank decoder.
`default_nettype none

package erd_pkg;

  localparam int CHAN_NUM   = 2;
  localparam int RANK_MAX   = 4;
  localparam int RANK_IDX_W = 2;
  localparam int MATCH_W    = CHAN_NUM * RANK_MAX;
  localparam int RANGE_W    = 22;
  localparam int DRB_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int PAGE_OUT_W = 21;
  localparam int OFS_W      = 12;

  // A boundary byte marks the top of a rank at page byte << (TOP_SHIFT_BASE - page bits).
  localparam int TOP_SHIFT_BASE = 25;
  localparam int GRAIN_SYM      = 128;
  localparam int GRAIN_ASYM     = 64;

  // Status read encoding and the address bit that picks the channel when interleaved.
  localparam int ST_CE_BIT    = 0;
  localparam int ST_UE_BIT    = 1;
  localparam int CHAN_SEL_BIT = 6;

  // Configuration register indexes.
  localparam logic REG_DRB_A = 1'b0;
  localparam logic REG_DRB_B = 1'b1;

  typedef struct packed {
    logic [1:0]  status_first;
    logic [1:0]  status_second;
    logic [31:0] error_address;
    logic        address_high_bit;
    logic [7:0]  ecc_syndrome;
  } in_t;

  typedef struct packed {
    logic        error_present;
    logic        overwrite_seen;
    logic        uncorrected;
    logic [20:0] page_number;
    logic [11:0] page_offset;
    logic [7:0]  syndrome_out;
    logic        rank_found;
    logic [1:0]  rank_index;
    logic        channel_index;
    logic        channel_known;
  } out_t;

  // Rank ranges derived from the boundary registers.
  typedef struct packed {
    logic                                            symmetric;
    logic [1:0]                                      channel_count;
    logic [CHAN_NUM-1:0][RANK_MAX-1:0]               valid;
    logic [CHAN_NUM-1:0][RANK_MAX-1:0][RANGE_W-1:0]  start;
    logic [CHAN_NUM-1:0][RANK_MAX-1:0][RANGE_W-1:0]  stop;
  } layout_t;

  localparam layout_t LAYOUT_RESET = '{symmetric: 1'b1, default: '0};

  // Middle pipeline stage: decoded fields and the per-rank match vector.
  typedef struct packed {
    logic               error_present;
    logic               overwrite_seen;
    logic               uncorrected;
    logic [20:0]        page_number;
    logic [11:0]        page_offset;
    logic [7:0]         syndrome;
    logic               chan_bit;
    logic [MATCH_W-1:0] match;
  } mid_t;

endpackage

`default_nettype wire

// ===== src/erd_layout.sv =====
// Boundary registers and the rank range table derived from them.
`default_nettype none

module erd_layout
  import erd_pkg::*;
#(
  parameter int PAGE_BITS         = 12,
  parameter int RANKS_PER_CHANNEL = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [DRB_W-1:0] cfg_data,
  output layout_t               layout
);

  localparam int TOP_SHIFT = TOP_SHIFT_BASE - PAGE_BITS;

  logic [DRB_W-1:0] drb_a;
  logic [DRB_W-1:0] drb_b;
  layout_t          layout_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      drb_a <= '0;
      drb_b <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRB_A: drb_a <= cfg_data;
        REG_DRB_B: drb_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // The running base of every rank but the first is the top of the rank before it,
  // whether or not that rank was empty, so every range is computed in parallel.
  always_comb begin
    logic [CHAN_NUM-1:0][RANK_MAX-1:0][BYTE_W-1:0]  bytes;
    logic [CHAN_NUM-1:0][RANK_MAX-1:0][RANGE_W-1:0] top;
    logic [RANGE_W-1:0] base;
    logic [RANGE_W-1:0] last;
    logic               sym;
    logic               has_a;
    logic               has_b;
    logic [1:0]         count;
    logic               chan_used;

    bytes = '0;
    top   = '0;
    sym   = 1'b1;
    has_a = 1'b0;
    has_b = 1'b0;
    for (int r = 0; r < RANKS_PER_CHANNEL; r++) begin
      bytes[0][r] = drb_a[BYTE_W*r +: BYTE_W];
      bytes[1][r] = drb_b[BYTE_W*r +: BYTE_W];
      if (bytes[0][r] != bytes[1][r]) begin
        sym = 1'b0;
      end
      if (bytes[0][r] != '0) begin
        has_a = 1'b1;
      end
      if (bytes[1][r] != '0) begin
        has_b = 1'b1;
      end
      for (int c = 0; c < CHAN_NUM; c++) begin
        top[c][r] = RANGE_W'(bytes[c][r]) << TOP_SHIFT;
      end
    end
    count = {1'b0, has_a} + {1'b0, has_b};

    layout_next               = '0;
    layout_next.symmetric     = sym;
    layout_next.channel_count = count;
    for (int c = 0; c < CHAN_NUM; c++) begin
      chan_used = (c == 0) ? (count != 2'd0) : (count == 2'd2);
      for (int r = 0; r < RANKS_PER_CHANNEL; r++) begin
        if (r == 0) begin
          base = (c == 0 || sym) ? '0 : top[0][RANKS_PER_CHANNEL-1];
        end else begin
          base = top[c][r-1];
        end
        last = top[c][r] - RANGE_W'(1);
        layout_next.valid[c][r] = chan_used && (top[c][r] != base);
        layout_next.start[c][r] = sym ? {base[RANGE_W-2:0], 1'b0} : base;
        layout_next.stop[c][r]  = sym ? {last[RANGE_W-2:0], 1'b0} : last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= LAYOUT_RESET;
    end else begin
      layout <= layout_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/dram_ecc_error_rank_decoder_top.sv =====
// Top level of the DRAM ECC error rank decoder: three-stage snapshot pipeline.
// A snapshot moves through the capture, decode and result registers in turn.
// Throughput: one snapshot per cycle while out_ready holds; the rank compares sit in the second stage.
// A register write takes effect on snapshots transferred from the next cycle on.
// Reset clears both boundary registers (symmetric mode, no channels, no ranks)
// and empties the pipeline.
`default_nettype none

module dram_ecc_error_rank_decoder_top
  import erd_pkg::*;
#(
  parameter int PAGE_BITS         = 12,
  parameter int RANKS_PER_CHANNEL = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [DRB_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data
);

  localparam logic [OFS_W-1:0] OFS_MASK_SYM  = OFS_W'((1 << PAGE_BITS) - GRAIN_SYM);
  localparam logic [OFS_W-1:0] OFS_MASK_ASYM = OFS_W'((1 << PAGE_BITS) - GRAIN_ASYM);

  layout_t layout;

  erd_layout #(
    .PAGE_BITS         (PAGE_BITS),
    .RANKS_PER_CHANNEL (RANKS_PER_CHANNEL)
  ) u_layout (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .layout    (layout)
  );

  logic  snap_valid;
  in_t   snap;
  logic  mid_valid;
  mid_t  mid;
  mid_t  mid_next;
  out_t  out_next;
  logic  mid_ready;
  logic  out_free;

  assign out_free  = !out_valid || out_ready;
  assign mid_ready = !mid_valid || out_free;
  assign in_ready  = !snap_valid || mid_ready;

  // Stage 1: capture the snapshot.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_ready) begin
      snap_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      snap <= in_data;
    end
  end

  // Stage 2: decode the status reads and compare the page against every rank.
  always_comb begin
    logic [32:0]        addr;
    logic [RANGE_W-1:0] page;

    addr = {snap.address_high_bit, snap.error_address};
    page = RANGE_W'(addr >> PAGE_BITS);

    mid_next                = '0;
    mid_next.error_present  = snap.status_second[ST_CE_BIT] | snap.status_second[ST_UE_BIT];
    mid_next.overwrite_seen = |(snap.status_first ^ snap.status_second);
    mid_next.uncorrected    = snap.status_second[ST_UE_BIT];
    mid_next.page_number    = page[PAGE_OUT_W-1:0];
    mid_next.page_offset    = snap.error_address[OFS_W-1:0] &
                              (layout.symmetric ? OFS_MASK_SYM : OFS_MASK_ASYM);
    mid_next.syndrome       = snap.ecc_syndrome;
    mid_next.chan_bit       = snap.error_address[CHAN_SEL_BIT];
    for (int c = 0; c < CHAN_NUM; c++) begin
      for (int r = 0; r < RANKS_PER_CHANNEL; r++) begin
        mid_next.match[c*RANK_MAX + r] = layout.valid[c][r] &&
                                         (page >= layout.start[c][r]) &&
                                         (page <= layout.stop[c][r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && snap_valid) begin
      mid <= mid_next;
    end
  end

  // Stage 3: pick the first matching rank, channel A first, and build the result.
  always_comb begin
    logic                found;
    logic [RANK_IDX_W-1:0] rank;
    logic                chan;

    found = 1'b0;
    rank  = '0;
    chan  = 1'b0;
    for (int i = MATCH_W - 1; i >= 0; i--) begin
      if (mid.match[i]) begin
        found = 1'b1;
        rank  = RANK_IDX_W'(i % RANK_MAX);
        chan  = 1'(i / RANK_MAX);
      end
    end

    out_next = '0;
    if (mid.error_present) begin
      out_next.error_present  = 1'b1;
      out_next.overwrite_seen = mid.overwrite_seen;
      out_next.uncorrected    = mid.uncorrected;
      out_next.page_number    = mid.page_number;
      out_next.page_offset    = mid.page_offset;
      out_next.rank_found     = found;
      out_next.rank_index     = rank;
      if (!mid.uncorrected) begin
        out_next.syndrome_out  = mid.syndrome;
        out_next.channel_known = found;
        if (found) begin
          out_next.channel_index = layout.symmetric ? mid.chan_bit : chan;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && mid_valid) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/erd_checker.sv =====
// Port-level checks of the DRAM ECC error rank decoder and their binding.
`default_nettype none

module erd_checker
  import erd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // A result that was not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // The pipeline is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Without an error the page, offset, rank, channel and status fields read zero.
  a_no_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.error_present |->
      out_data.page_number == '0 && out_data.page_offset == '0 &&
      out_data.rank_found == 1'b0 && out_data.channel_known == 1'b0 &&
      out_data.uncorrected == 1'b0 && out_data.overwrite_seen == 1'b0)
    else $error("fields set without an error");

  // An uncorrected error carries no syndrome and no channel.
  a_uncorrected_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.uncorrected |->
      out_data.syndrome_out == '0 && out_data.channel_known == 1'b0 &&
      out_data.channel_index == 1'b0)
    else $error("uncorrected error reports syndrome or channel");

  // A channel is only known for an error that hit a rank.
  a_channel_needs_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.channel_known |-> out_data.rank_found)
    else $error("channel known without a rank match");

endmodule

bind dram_ecc_error_rank_decoder_top erd_checker u_erd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
